[rtl/gta_pkg.sv]
// Shared types and constants of the gated track association block.
// Used by gta_div and gated_track_association_top; no dependencies.
`default_nettype none

package gta_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned NUM_W   = 48;
  localparam int unsigned DEN_W   = 17;
  localparam int unsigned IDX_W   = 5;

  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_ASSOC   = 2'd0,
    KIND_PUBLISH = 2'd1,
    KIND_DONE    = 2'd2
  } kind_e;

  typedef enum logic [0:0] {
    CFG_GATE    = 1'b0,
    CFG_MIN_OBS = 1'b1
  } cfg_index_e;

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_GATE     = 18'h00002,
    S_RD       = 18'h00004,
    S_LAT      = 18'h00008,
    S_SQ       = 18'h00010,
    S_CMP      = 18'h00020,
    S_UPD_RD   = 18'h00040,
    S_UPD_LAT  = 18'h00080,
    S_MUL      = 18'h00100,
    S_DIV_GO   = 18'h00200,
    S_DIV_WAIT = 18'h00400,
    S_WR       = 18'h00800,
    S_NEW      = 18'h01000,
    S_DROP     = 18'h02000,
    S_FR_RD    = 18'h04000,
    S_FR_LAT   = 18'h08000,
    S_FR_CHK   = 18'h10000,
    S_FR_DONE  = 18'h20000
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [CNT_W-1:0]          cnt;
    logic                      pub;
  } entry_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    kind_e                     kind;
    logic [IDX_W-1:0]          idx;
    logic                      created;
    logic                      dropped;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [CNT_W-1:0]          cnt;
    logic                      last;
  } out_t;

endpackage

`default_nettype wire

[rtl/gta_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module gta_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          we_i,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]              wdata_i,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[rtl/gta_div.sv]
// Restoring divider, one quotient bit per cycle, for the running mean.
// Depends on gta_pkg.
`default_nettype none

module gta_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gta_pkg::div_req_t req_i,
  output gta_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned CW = $clog2(gta_pkg::NUM_W + 1);

  logic [gta_pkg::NUM_W-1:0] dvd_q, dvd_d;
  logic [gta_pkg::DEN_W-1:0] den_q, den_d;
  logic [gta_pkg::DEN_W-1:0] rem_q, rem_d;
  logic [CW-1:0]             cnt_q, cnt_d;
  logic                      done_q, done_d;
  logic [gta_pkg::DEN_W:0]   rem_sh;
  logic                      qbit;

  always_comb begin
    rem_sh = {rem_q, dvd_q[gta_pkg::NUM_W-1]};
    qbit   = (rem_sh >= {1'b0, den_q});
    dvd_d  = dvd_q;
    den_d  = den_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d = req_i.dividend;
      den_d = req_i.divisor;
      rem_d = '0;
      cnt_d = CW'(gta_pkg::NUM_W);
    end else if (cnt_q != '0) begin
      if (qbit) begin
        rem_d = gta_pkg::DEN_W'(rem_sh - {1'b0, den_q});
      end else begin
        rem_d = rem_sh[gta_pkg::DEN_W-1:0];
      end
      dvd_d  = {dvd_q[gta_pkg::NUM_W-2:0], qbit};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    den_q <= den_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

`default_nettype wire

[rtl/gated_track_association_top.sv]
// Top level of the gated track association block: sequencer, track RAM
// and mean divider. Depends on gta_pkg, gta_ram and gta_div.
//
// Usage: points and end-of-frame requests enter on s_axis (tuser bit 0 is
// 1 for end of frame, tdata holds x, y, z). Results leave on m_axis, one per
// point request, and for end of frame one per published track followed by
// a done result with tlast high. Registers are written on the cfg channel
// (index 0 gate radius, index 1 minimum observations); the user must write
// them only while idle, as the block itself does not enforce this. Track
// state sits in one RAM entry per track; each request reads, updates and
// writes entries one at a time, so one request is in flight. A point scans
// every track in use (read, register, three squares through one multiplier,
// compare) and, when it joins a track, then runs three divisions on the
// single divider. End of frame reads and checks every track in use.
// The result sits in an output register; a stalled receiver holds the
// sequencer only when the next result is ready to load.
// Reset empties the table and restores the register defaults; no RAM
// clearing pass is needed since only opened entries are read.
`default_nettype none

module gated_track_association_top #(
  parameter int unsigned MAX_TRACKS = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  // x [31:0], y [63:32], z [95:64]
  input  wire logic [95:0]   s_axis_tdata_i,
  // func [0]
  input  wire logic [0:0]    s_axis_tuser_i,
  output logic               m_axis_tvalid_o,
  input  wire logic          m_axis_tready_i,
  // track_index [4:0], pos_x [36:5], pos_y [68:37], pos_z [100:69],
  // obs_count [116:101], zero fill [119:117]
  output logic [119:0]       m_axis_tdata_o,
  // kind [1:0], created [2], dropped [3]
  output logic [3:0]         m_axis_tuser_o,
  output logic               m_axis_tlast_o,
  input  wire logic          cfg_valid_i,
  output logic               cfg_ready_o,
  input  wire logic [0:0]    cfg_index_i,
  input  wire logic [31:0]   cfg_data_i
);

  localparam int unsigned IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned TW = $clog2(MAX_TRACKS + 1);
  localparam int unsigned EW = $bits(gta_pkg::entry_t);

  gta_pkg::state_e state_q, state_d;

  logic [31:0]             gate_q;
  logic [15:0]             min_obs_q;
  logic [TW-1:0]           tiu_q, tiu_d;
  logic [TW-1:0]           idx_q, idx_d;
  logic [TW-1:0]           best_q, best_d;
  logic                    found_q, found_d;
  logic [63:0]             best_lo_q, best_lo_d;
  logic [63:0]             gate2_q, gate2_d;
  logic [1:0]              k_q, k_d;
  logic [63:0]             sq_q, sq_d;
  logic [65:0]             acc_q, acc_d;
  logic signed [48:0]      num_q, num_d;
  logic signed [31:0]      px_q, py_q, pz_q;
  gta_pkg::entry_t         ent_q, ent_d;
  logic                    m_valid_q, m_valid_d;
  gta_pkg::out_t           out_q, out_d;

  logic                    ram_we;
  logic [IW-1:0]           ram_waddr, ram_raddr;
  gta_pkg::entry_t         ram_wdata;
  logic [EW-1:0]           ram_rdata;
  gta_pkg::div_req_t       div_req;
  gta_pkg::div_rsp_t       div_rsp;

  logic                    in_acc, out_free, out_load;
  logic signed [31:0]      mean_k, pt_k;
  logic signed [32:0]      diff;
  logic [31:0]             mag;
  logic signed [48:0]      prod;
  logic [47:0]             num_mag;
  logic [16:0]             den;
  logic [31:0]             qres;
  logic [15:0]             cnt_inc;

  gta_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_TRACKS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  gta_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign s_axis_tready_o = (state_q == gta_pkg::S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  always_comb begin
    case (k_q)
      2'd0:    begin mean_k = ent_q.x; pt_k = px_q; end
      2'd1:    begin mean_k = ent_q.y; pt_k = py_q; end
      default: begin mean_k = ent_q.z; pt_k = pz_q; end
    endcase
    diff    = {mean_k[31], mean_k} - {pt_k[31], pt_k};
    mag     = diff[32] ? 32'(-diff) : diff[31:0];
    prod    = mean_k * $signed({1'b0, ent_q.cnt});
    num_mag = num_q[48] ? 48'(-num_q) : num_q[47:0];
    den     = {1'b0, ent_q.cnt} + 17'd1;
    qres    = num_q[48] ? -div_rsp.quotient[31:0] : div_rsp.quotient[31:0];
    cnt_inc = (ent_q.cnt == gta_pkg::COUNT_MAX) ? ent_q.cnt : ent_q.cnt + 16'd1;
  end

  always_comb begin
    state_d   = state_q;
    tiu_d     = tiu_q;
    idx_d     = idx_q;
    best_d    = best_q;
    found_d   = found_q;
    best_lo_d = best_lo_q;
    gate2_d   = gate2_q;
    k_d       = k_q;
    sq_d      = sq_q;
    acc_d     = acc_q;
    num_d     = num_q;
    ent_d     = ent_q;
    out_d     = out_q;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = best_q[IW-1:0];
    ram_wdata = ent_q;
    ram_raddr = idx_q[IW-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = num_mag + 48'(den >> 1);
    div_req.divisor  = den;

    case (state_q)
      gta_pkg::S_IDLE: begin
        idx_d   = '0;
        found_d = 1'b0;
        if (in_acc) begin
          state_d = s_axis_tuser_i[0] ? gta_pkg::S_FR_RD : gta_pkg::S_GATE;
        end
      end
      gta_pkg::S_GATE: begin
        gate2_d = {32'b0, gate_q} * {32'b0, gate_q};
        state_d = gta_pkg::S_RD;
      end
      gta_pkg::S_RD: begin
        if (idx_q == tiu_q) begin
          if (found_q) begin
            state_d = gta_pkg::S_UPD_RD;
          end else if (tiu_q < TW'(MAX_TRACKS)) begin
            state_d = gta_pkg::S_NEW;
          end else begin
            state_d = gta_pkg::S_DROP;
          end
        end else begin
          state_d = gta_pkg::S_LAT;
        end
      end
      gta_pkg::S_LAT: begin
        ent_d   = gta_pkg::entry_t'(ram_rdata);
        k_d     = 2'd0;
        acc_d   = '0;
        state_d = gta_pkg::S_SQ;
      end
      gta_pkg::S_SQ: begin
        if (k_q != 2'd3) begin
          sq_d = {32'b0, mag} * {32'b0, mag};
        end
        if (k_q != 2'd0) begin
          acc_d = acc_q + {2'b0, sq_q};
        end
        k_d = k_q + 2'd1;
        if (k_q == 2'd3) begin
          state_d = gta_pkg::S_CMP;
        end
      end
      gta_pkg::S_CMP: begin
        if ((acc_q <= {2'b0, gate2_q}) && (!found_q || (acc_q[63:0] < best_lo_q))) begin
          found_d   = 1'b1;
          best_d    = idx_q;
          best_lo_d = acc_q[63:0];
        end
        idx_d   = idx_q + 1'b1;
        state_d = gta_pkg::S_RD;
      end
      gta_pkg::S_UPD_RD: begin
        ram_raddr = best_q[IW-1:0];
        state_d   = gta_pkg::S_UPD_LAT;
      end
      gta_pkg::S_UPD_LAT: begin
        ent_d   = gta_pkg::entry_t'(ram_rdata);
        k_d     = 2'd0;
        state_d = gta_pkg::S_MUL;
      end
      gta_pkg::S_MUL: begin
        num_d   = prod + 49'(pt_k);
        state_d = gta_pkg::S_DIV_GO;
      end
      gta_pkg::S_DIV_GO: begin
        div_req.start = 1'b1;
        state_d       = gta_pkg::S_DIV_WAIT;
      end
      gta_pkg::S_DIV_WAIT: begin
        if (div_rsp.done) begin
          case (k_q)
            2'd0:    ent_d.x = qres;
            2'd1:    ent_d.y = qres;
            default: ent_d.z = qres;
          endcase
          k_d     = k_q + 2'd1;
          state_d = (k_q == 2'd2) ? gta_pkg::S_WR : gta_pkg::S_MUL;
        end
      end
      gta_pkg::S_WR: begin
        if (out_free) begin
          ram_we        = 1'b1;
          ram_wdata.cnt = cnt_inc;
          out_load      = 1'b1;
          out_d.kind    = gta_pkg::KIND_ASSOC;
          out_d.idx     = gta_pkg::IDX_W'(best_q);
          out_d.created = 1'b0;
          out_d.dropped = 1'b0;
          out_d.x       = ent_q.x;
          out_d.y       = ent_q.y;
          out_d.z       = ent_q.z;
          out_d.cnt     = cnt_inc;
          out_d.last    = 1'b1;
          state_d       = gta_pkg::S_IDLE;
        end
      end
      gta_pkg::S_NEW: begin
        if (out_free) begin
          ram_we        = 1'b1;
          ram_waddr     = tiu_q[IW-1:0];
          ram_wdata.x   = px_q;
          ram_wdata.y   = py_q;
          ram_wdata.z   = pz_q;
          ram_wdata.cnt = 16'd1;
          ram_wdata.pub = 1'b0;
          tiu_d         = tiu_q + 1'b1;
          out_load      = 1'b1;
          out_d.kind    = gta_pkg::KIND_ASSOC;
          out_d.idx     = gta_pkg::IDX_W'(tiu_q);
          out_d.created = 1'b1;
          out_d.dropped = 1'b0;
          out_d.x       = px_q;
          out_d.y       = py_q;
          out_d.z       = pz_q;
          out_d.cnt     = 16'd1;
          out_d.last    = 1'b1;
          state_d       = gta_pkg::S_IDLE;
        end
      end
      gta_pkg::S_DROP: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_d.kind    = gta_pkg::KIND_ASSOC;
          out_d.idx     = '0;
          out_d.created = 1'b0;
          out_d.dropped = 1'b1;
          out_d.x       = px_q;
          out_d.y       = py_q;
          out_d.z       = pz_q;
          out_d.cnt     = '0;
          out_d.last    = 1'b1;
          state_d       = gta_pkg::S_IDLE;
        end
      end
      gta_pkg::S_FR_RD: begin
        state_d = (idx_q == tiu_q) ? gta_pkg::S_FR_DONE : gta_pkg::S_FR_LAT;
      end
      gta_pkg::S_FR_LAT: begin
        ent_d   = gta_pkg::entry_t'(ram_rdata);
        state_d = gta_pkg::S_FR_CHK;
      end
      gta_pkg::S_FR_CHK: begin
        if (ent_q.pub || (ent_q.cnt < min_obs_q)) begin
          idx_d   = idx_q + 1'b1;
          state_d = gta_pkg::S_FR_RD;
        end else if (out_free) begin
          ram_we        = 1'b1;
          ram_waddr     = idx_q[IW-1:0];
          ram_wdata.pub = 1'b1;
          out_load      = 1'b1;
          out_d.kind    = gta_pkg::KIND_PUBLISH;
          out_d.idx     = gta_pkg::IDX_W'(idx_q);
          out_d.created = 1'b0;
          out_d.dropped = 1'b0;
          out_d.x       = ent_q.x;
          out_d.y       = ent_q.y;
          out_d.z       = ent_q.z;
          out_d.cnt     = ent_q.cnt;
          out_d.last    = 1'b0;
          idx_d         = idx_q + 1'b1;
          state_d       = gta_pkg::S_FR_RD;
        end
      end
      gta_pkg::S_FR_DONE: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_d.kind    = gta_pkg::KIND_DONE;
          out_d.idx     = '0;
          out_d.created = 1'b0;
          out_d.dropped = 1'b0;
          out_d.x       = '0;
          out_d.y       = '0;
          out_d.z       = '0;
          out_d.cnt     = '0;
          out_d.last    = 1'b1;
          state_d       = gta_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = gta_pkg::S_IDLE;
      end
    endcase

    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gta_pkg::S_IDLE;
      tiu_q     <= '0;
      m_valid_q <= 1'b0;
      gate_q    <= 32'd131072;
      min_obs_q <= 16'd5;
      found_q   <= 1'b0;
      idx_q     <= '0;
      k_q       <= '0;
    end else begin
      state_q   <= state_d;
      tiu_q     <= tiu_d;
      m_valid_q <= m_valid_d;
      found_q   <= found_d;
      idx_q     <= idx_d;
      k_q       <= k_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (gta_pkg::cfg_index_e'(cfg_index_i))
          gta_pkg::CFG_GATE:    gate_q    <= cfg_data_i;
          gta_pkg::CFG_MIN_OBS: min_obs_q <= cfg_data_i[15:0];
          default:              gate_q    <= gate_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= s_axis_tdata_i[31:0];
      py_q <= s_axis_tdata_i[63:32];
      pz_q <= s_axis_tdata_i[95:64];
    end
    best_q    <= best_d;
    best_lo_q <= best_lo_d;
    gate2_q   <= gate2_d;
    sq_q      <= sq_d;
    acc_q     <= acc_d;
    num_q     <= num_d;
    ent_q     <= ent_d;
    out_q     <= out_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {3'b0, out_q.cnt, out_q.z, out_q.y, out_q.x, out_q.idx};
  assign m_axis_tuser_o  = {out_q.dropped, out_q.created, out_q.kind};
  assign m_axis_tlast_o  = out_q.last;

  a_tiu_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tiu_q <= TW'(MAX_TRACKS))
    else $error("track count beyond table size");

  a_tiu_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tiu_q != $past(tiu_q)) |-> (tiu_q == $past(tiu_q) + 1'b1))
    else $error("track count moved by more than one");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!m_valid_q || m_axis_tready_i))
    else $error("result overwritten while waiting");

  a_ram_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == gta_pkg::S_WR || state_q == gta_pkg::S_NEW ||
                state_q == gta_pkg::S_FR_CHK))
    else $error("track write outside an update step");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == gta_pkg::S_DIV_WAIT))
    else $error("division finished with no request pending");

endmodule

`default_nettype wire
